// ===== rtl/wdt_pkg.sv =====
// ----------------------------------------------------------------------------
// wdt_pkg: shared types and constants for the weighted draw table
// field widths, operation and status codes, controller states and the
// command and status bundles between controller and datapath
// ----------------------------------------------------------------------------
package wdt_pkg;

  // field widths on the stream ports
  localparam int MODE_W      = 2;
  localparam int ID_W        = 32;
  localparam int WEIGHT_IN_W = 16;
  localparam int RAND_W      = 24;
  localparam int STATUS_W    = 2;
  localparam int TOTAL_OUT_W = 24;
  localparam int COUNT_OUT_W = 9;

  localparam int S_DATA_W = 72;
  localparam int S_USER_W = MODE_W;
  localparam int M_DATA_W = 72;
  localparam int M_USER_W = STATUS_W;
  localparam int M_PAD_W  = M_DATA_W - (ID_W + TOTAL_OUT_W + COUNT_OUT_W);

  // operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DRAW   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_REM_SCAN,
    ST_REM_SHIFT,
    ST_DRAW_SCAN,
    ST_FINISH
  } wdt_state_t;

  typedef struct packed {
    logic                accept;
    logic                insert;
    logic                scan_start;
    logic                scan_step;
    logic                shift_start;
    logic                shift_step;
    logic                rem_commit;
    logic                res_we;
    logic [STATUS_W-1:0] res_status;
    logic                res_take_id;
    logic                out_load;
  } wdt_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] in_mode;
    logic              full;
    logic              quick_miss;
    logic              id_hit;
    logic              range_hit;
    logic              scan_end;
    logic              out_free;
  } wdt_stat_t;

endpackage

// ===== rtl/weighted_draw_table.sv =====
// ----------------------------------------------------------------------------
// weighted_draw_table: roulette-wheel table of weighted entries
// insert appends an id with a weight, remove deletes the first entry with an
// id, draw returns the id whose cumulative weight range holds a random value
// ----------------------------------------------------------------------------
// latency from accept to result valid depends on the mode: an unused
//   mode goes straight to finish, insert passes its own state, and draw
// and remove sweep the entry ram, one entry read per cycle; a remove
//   searches up to the hit and then slides the later entries down
// one item at a time: the next item is taken the cycle after the result is
//   loaded into the output register, which holds it until the sink takes it
// reset clears count, total and the control path and holds the input off;
//   ram contents stay undefined, only entries below the count are ever read
// ----------------------------------------------------------------------------
module weighted_draw_table
  import wdt_pkg::*;
#(
  parameter int MAX_ENTRIES = 256,
  parameter int WEIGHT_BITS = 16,
  parameter int TOTAL_BITS  = 24
) (
  input  logic                clk,
  input  logic                rst,
  // input items
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // item_id[31:0], weight[47:32], random_value[71:48]
  input  logic [S_USER_W-1:0] s_tuser,  // mode[1:0]
  // result items
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // drawn_id[31:0], total_weight[55:32],
                                        // entry_count[64:56], zero pad above
  output logic [M_USER_W-1:0] m_tuser   // status[1:0]
);

  // command and status bundles between the sequencer and the datapath
  wdt_cmd_t  cmd;
  wdt_stat_t stat;

  // sequencer: picks the operation from the item's mode and steps the scans
  wdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: entry ram holding id and range width per entry; ranges are
  // contiguous so each start is the sum of the widths before it, which the
  // draw scan rebuilds as it walks the table
  wdt_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS),
    .TOTAL_BITS  (TOTAL_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== rtl/wdt_ram.sv =====
// ----------------------------------------------------------------------------
// wdt_ram: generic simple dual-port ram
// one write port and one read port, read data registered
// ----------------------------------------------------------------------------
module wdt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/wdt_dpath.sv =====
// ----------------------------------------------------------------------------
// wdt_dpath: datapath of the weighted draw table
// entry ram, scan index, running sums, count and total, result register
// ----------------------------------------------------------------------------
module wdt_dpath
  import wdt_pkg::*;
#(
  parameter int MAX_ENTRIES = 256,
  parameter int WEIGHT_BITS = 16,
  parameter int TOTAL_BITS  = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  wdt_cmd_t            cmd,
  output wdt_stat_t           stat,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic [S_USER_W-1:0] s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic [M_USER_W-1:0] m_tuser
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int MW = ID_W + WEIGHT_BITS;
  localparam int XW = (TOTAL_BITS > RAND_W) ? TOTAL_BITS : RAND_W;
  localparam int SW = ((TOTAL_BITS > WEIGHT_BITS) ? TOTAL_BITS : WEIGHT_BITS) + 1;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  // captured item
  logic [ID_W-1:0]        id_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic [RAND_W-1:0]      rand_q;

  // table state
  logic [CW-1:0]         count;
  logic [TOTAL_BITS-1:0] total;

  // scan pipeline
  logic [CW-1:0]          idx;
  logic [AW-1:0]          pidx;
  logic                   pend;
  logic [TOTAL_BITS-1:0]  cum;
  logic [TOTAL_BITS-1:0]  cum_next;
  logic [WEIGHT_BITS-1:0] rem_w;

  // result
  logic [STATUS_W-1:0] res_status;
  logic [ID_W-1:0]     res_drawn;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_drawn;
  logic [TOTAL_OUT_W-1:0] out_total;
  logic [COUNT_OUT_W-1:0] out_count;

  // ram
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [MW-1:0]          wr_data;
  logic [MW-1:0]          rd_data;
  logic [ID_W-1:0]        rd_id;
  logic [WEIGHT_BITS-1:0] rd_w;

  // insert arithmetic
  logic [SW-1:0]          ins_sum;
  logic [TOTAL_BITS-1:0]  ins_end;
  logic [WEIGHT_BITS-1:0] ins_width;

  assign rd_id = rd_data[WEIGHT_BITS +: ID_W];
  assign rd_w  = rd_data[WEIGHT_BITS-1:0];

  assign ins_sum   = SW'(total) + SW'(w_q);
  assign ins_end   = (ins_sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_BITS'(ins_sum);
  assign ins_width = WEIGHT_BITS'(ins_end - total);

  assign cum_next = cum + TOTAL_BITS'(rd_w);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = {id_q, ins_width};
    if (cmd.insert && !stat.full) begin
      wr_en = 1'b1;
    end else if (cmd.shift_step && pend) begin
      wr_en   = 1'b1;
      wr_addr = pidx - AW'(1);
      wr_data = rd_data;
    end
  end

  wdt_ram #(
    .WIDTH(MW),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    stat.in_mode    = s_tuser;
    stat.full       = (count == CW'(MAX_ENTRIES));
    stat.quick_miss = (count == '0) || (XW'(rand_q) >= XW'(total));
    stat.id_hit     = pend && (rd_id == id_q);
    stat.range_hit  = pend && (XW'(rand_q) < XW'(cum_next));
    stat.scan_end   = !pend && (idx >= count);
    stat.out_free   = !m_tvalid || m_tready;
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      id_q   <= s_tdata[ID_W-1:0];
      w_q    <= WEIGHT_BITS'(s_tdata[ID_W +: WEIGHT_IN_W]);
      rand_q <= s_tdata[ID_W + WEIGHT_IN_W +: RAND_W];
    end
  end

  // count and total
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (cmd.insert && !stat.full) begin
      count <= count + CW'(1);
      total <= ins_end;
    end else if (cmd.rem_commit) begin
      count <= count - CW'(1);
      total <= total - TOTAL_BITS'(rem_w);
    end
  end

  // scan index and pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      idx  <= '0;
    end else if (cmd.scan_start) begin
      pend <= 1'b0;
      idx  <= '0;
    end else if (cmd.shift_start) begin
      pend <= 1'b0;
      idx  <= CW'(pidx) + CW'(1);
    end else if (cmd.scan_step || cmd.shift_step) begin
      pend <= (idx < count);
      if (idx < count) begin
        idx <= idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step || cmd.shift_step) begin
      pidx <= idx[AW-1:0];
    end
    if (cmd.scan_start) begin
      cum <= '0;
    end else if (cmd.scan_step && pend) begin
      cum <= cum_next;
    end
    if (cmd.shift_start) begin
      rem_w <= rd_w;
    end
    if (cmd.res_we) begin
      res_status <= cmd.res_status;
      res_drawn  <= cmd.res_take_id ? rd_id : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_drawn  <= res_drawn;
      out_total  <= TOTAL_OUT_W'(total);
      out_count  <= COUNT_OUT_W'(count);
    end
  end

  assign m_tdata = {{M_PAD_W{1'b0}}, out_count, out_total, out_drawn};
  assign m_tuser = out_status;

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

  a_commit_nonempty : assert property (@(posedge clk) disable iff (rst)
    cmd.rem_commit |-> (count != '0) && (TOTAL_BITS'(rem_w) <= total))
    else $error("remove commit on empty table or oversize width");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    cmd.insert && !stat.full |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the table");

  a_load_free : assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over an untaken item");

endmodule

// ===== rtl/wdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// wdt_ctrl: controller of the weighted draw table
// sequences insert, remove (search then slide) and draw scans
// ----------------------------------------------------------------------------
module wdt_ctrl
  import wdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  wdt_stat_t stat,
  output wdt_cmd_t  cmd
);

  wdt_state_t state;
  wdt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.accept = 1'b1;
          case (stat.in_mode)
            MODE_INSERT: begin
              state_next = ST_INSERT;
            end
            MODE_REMOVE: begin
              cmd.scan_start = 1'b1;
              state_next     = ST_REM_SCAN;
            end
            MODE_DRAW: begin
              cmd.scan_start = 1'b1;
              state_next     = ST_DRAW_SCAN;
            end
            default: begin
              cmd.res_we     = 1'b1;
              cmd.res_status = STATUS_DONE;
              state_next     = ST_FINISH;
            end
          endcase
        end
      end
      ST_INSERT: begin
        cmd.insert     = 1'b1;
        cmd.res_we     = 1'b1;
        cmd.res_status = stat.full ? STATUS_FULL : STATUS_DONE;
        state_next     = ST_FINISH;
      end
      ST_REM_SCAN: begin
        if (stat.id_hit) begin
          cmd.shift_start = 1'b1;
          state_next      = ST_REM_SHIFT;
        end else if (stat.scan_end) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = STATUS_MISS;
          state_next     = ST_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_REM_SHIFT: begin
        if (stat.scan_end) begin
          cmd.rem_commit = 1'b1;
          cmd.res_we     = 1'b1;
          cmd.res_status = STATUS_DONE;
          state_next     = ST_FINISH;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      ST_DRAW_SCAN: begin
        if (stat.quick_miss || stat.scan_end) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = STATUS_MISS;
          state_next     = ST_FINISH;
        end else if (stat.range_hit) begin
          cmd.res_we      = 1'b1;
          cmd.res_status  = STATUS_DONE;
          cmd.res_take_id = 1'b1;
          state_next      = ST_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
